@@ rtl/core/ngme_pkg.sv @@
// ----------------------------------------------------------------------------
// ngme_pkg
// Widths, limits and saturation helper for the 2x2 natural gradient unit.
// ----------------------------------------------------------------------------
package ngme_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int DIV_W = DW + FB;
  localparam int RAD_W = 2 * DW;

  typedef logic signed [DW-1:0] word_t;

  localparam word_t MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(DW-1){1'b0}}};

  function automatic word_t sat66(input logic signed [65:0] v);
    word_t r;
    if (v > 66'(signed'(MAXV))) begin
      r = MAXV;
    end else if (v < 66'(signed'(MINV))) begin
      r = MINV;
    end else begin
      r = word_t'(v[DW-1:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ngme_mul.sv @@
// ----------------------------------------------------------------------------
// ngme_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ngme_mul (
  input  logic               clk,
  input  logic signed [33:0] op_a,
  input  logic signed [33:0] op_b,
  output logic signed [67:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

@@ rtl/core/ngme_div.sv @@
// ----------------------------------------------------------------------------
// ngme_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ngme_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ngme_pkg::DIV_W-1:0]  num,
  input  logic [ngme_pkg::DW-2:0]     den,
  output logic [ngme_pkg::DIV_W-1:0]  quo,
  output logic                        done
);

  logic                       busy;
  logic [5:0]                 cnt;
  logic [ngme_pkg::DW-2:0]    rem;
  logic [ngme_pkg::DW-1:0]    trial;
  logic                       take;

  assign trial = {rem, quo[ngme_pkg::DIV_W-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(ngme_pkg::DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= take ? (ngme_pkg::DW-1)'(trial - {1'b0, den}) : trial[ngme_pkg::DW-2:0];
      quo <= {quo[ngme_pkg::DIV_W-2:0], take};
    end
  end

endmodule

@@ rtl/core/ngme_sqrt.sv @@
// ----------------------------------------------------------------------------
// ngme_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ngme_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ngme_pkg::RAD_W-1:0]  rad,
  output logic [ngme_pkg::DW-1:0]     root,
  output logic                        done
);

  logic                        busy;
  logic [4:0]                  cnt;
  logic [ngme_pkg::RAD_W-1:0]  x;
  logic [33:0]                 rem;
  logic [35:0]                 cand;
  logic [35:0]                 trial;
  logic                        take;

  assign cand  = {rem, x[ngme_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign take  = cand >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x    <= {x[ngme_pkg::RAD_W-3:0], 2'b00};
      rem  <= take ? 34'(cand - trial) : cand[33:0];
      root <= {root[ngme_pkg::DW-2:0], take};
    end
  end

endmodule

@@ rtl/core/natural_gradient_2x2_min_eigen_unit.sv @@
// ----------------------------------------------------------------------------
// natural_gradient_2x2_min_eigen_unit
// Natural gradient of a symmetric 2x2 Fisher matrix with a running minimum
// of its smaller eigenvalue.
// ----------------------------------------------------------------------------
// The slave channel takes one item per dimension: the three matrix entries and
// the two gradient components in s_tdata, with s_tlast on the last dimension.
// The master channel returns one item per input: both natural gradient
// components and the running minimum eigenvalue in m_tdata, the singular flag
// in m_tuser and the copy of the last mark in m_tlast.
// One item is worked at a time and s_tready is low while it is in flight.
// A regular matrix goes from acceptance to the result through
// three products, 32 square root steps and three 48-step divisions, then
// four more products, all on one shared multiplier, divider and root unit.
// A singular matrix skips the divisions.
// The finished result sits in an output register; the next item is accepted
// while it waits, and a new result stalls until the receiver takes the old.
// The running minimum returns to the largest value after the last item of a
// vector and at reset, which also empties the output register.
// ----------------------------------------------------------------------------
module natural_gradient_2x2_min_eigen_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // fisher_aa, fisher_bb, fisher_ab, grad_a, grad_b
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // nat_a, nat_b, min_eigen
  output logic         m_tuser,   // singular
  output logic         m_tlast
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_SQS  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]           state;
  logic [2:0]           cnt;
  logic [1:0]           k;
  ngme_pkg::word_t      aa, bb, ab, ga, gb;
  logic                 eov;
  logic signed [63:0]   p_aabb;
  logic [63:0]          p_ab2;
  logic [64:0]          p_d2;
  ngme_pkg::word_t      det;
  logic                 sing;
  ngme_pkg::word_t      ev;
  ngme_pkg::word_t      g11, g12, g22;
  logic signed [63:0]   pf0, pf1, pf2, pf3;
  ngme_pkg::word_t      running_min;
  ngme_pkg::word_t      out_a, out_b, out_min;
  logic                 out_sing, out_last;

  logic signed [33:0]   op_a, op_b;
  logic signed [67:0]   prod;
  logic signed [32:0]   dif;
  logic [32:0]          ud;
  logic signed [64:0]   dwide;
  ngme_pkg::word_t      det_c;
  logic [63:0]          rad;
  logic                 sq_start, sq_done;
  logic [31:0]          root;
  logic signed [32:0]   tr;
  logic signed [33:0]   ev_w;
  ngme_pkg::word_t      dx;
  logic                 dneg;
  logic [31:0]          dmag;
  logic [47:0]          dnum;
  logic                 dv_start, dv_done;
  logic [47:0]          quo;
  ngme_pkg::word_t      qsat;
  ngme_pkg::word_t      na_c, nb_c, cur_c;
  logic                 load;

  ngme_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));

  ngme_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(rad), .root(root), .done(sq_done)
  );

  ngme_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dnum), .den(det[30:0]),
    .quo(quo), .done(dv_done)
  );

  assign s_tready = (state == S_IDLE);
  assign load     = (state == S_OUT) && (!m_tvalid || m_tready);

  assign dif   = 33'(aa) - 33'(bb);
  assign ud    = dif[32] ? 33'(-dif) : 33'(dif);
  assign dwide = 65'(p_aabb) - 65'(signed'({1'b0, p_ab2}));
  assign det_c = ngme_pkg::sat66(66'(dwide >>> ngme_pkg::FB));
  assign rad   = 64'(p_d2 >> 2) + p_ab2;
  assign tr    = 33'(aa) + 33'(bb);
  assign ev_w  = 34'(tr >>> 1) - 34'(signed'({2'b00, root}));

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == S_PRE) begin
      unique case (cnt)
        3'd0:    begin op_a = 34'(aa); op_b = 34'(bb); end
        3'd1:    begin op_a = 34'(ab); op_b = 34'(ab); end
        default: begin op_a = signed'({1'b0, ud}); op_b = signed'({1'b0, ud}); end
      endcase
    end else if (sing) begin
      unique case (cnt)
        3'd0:    begin op_a = 34'(bb); op_b = 34'(ga); end
        3'd1:    begin op_a = 34'(ab); op_b = 34'(gb); end
        3'd2:    begin op_a = 34'(aa); op_b = 34'(gb); end
        default: begin op_a = 34'(ab); op_b = 34'(ga); end
      endcase
    end else begin
      unique case (cnt)
        3'd0:    begin op_a = 34'(g11); op_b = 34'(ga); end
        3'd1:    begin op_a = 34'(g12); op_b = 34'(gb); end
        3'd2:    begin op_a = 34'(g12); op_b = 34'(ga); end
        default: begin op_a = 34'(g22); op_b = 34'(gb); end
      endcase
    end
  end

  always_comb begin
    unique case (k)
      2'd0:    begin dx = bb; dneg = bb[31]; end
      2'd1:    begin dx = aa; dneg = aa[31]; end
      default: begin dx = ab; dneg = !ab[31] && (ab != '0); end
    endcase
    dmag = dx[31] ? 32'(-dx) : 32'(dx);
    dnum = {dmag, 16'h0000};
    if (|quo[47:31]) begin
      qsat = dneg ? ngme_pkg::MINV : ngme_pkg::MAXV;
    end else begin
      qsat = dneg ? 32'(-{1'b0, quo[30:0]}) : {1'b0, quo[30:0]};
    end
  end

  always_comb begin
    if (sing) begin
      na_c = (pf0 >= pf1) ? ngme_pkg::MAXV : ngme_pkg::MINV;
      nb_c = (pf2 >= pf3) ? ngme_pkg::MAXV : ngme_pkg::MINV;
    end else begin
      na_c = ngme_pkg::sat66(66'(pf0 >>> ngme_pkg::FB) + 66'(pf1 >>> ngme_pkg::FB));
      nb_c = ngme_pkg::sat66(66'(pf2 >>> ngme_pkg::FB) + 66'(pf3 >>> ngme_pkg::FB));
    end
    cur_c = (ev < running_min) ? ev : running_min;
  end

  assign sq_start = (state == S_SQS);
  assign dv_start = (state == S_DIVS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      k           <= '0;
      running_min <= ngme_pkg::MAXV;
      m_tvalid    <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_PRE;
            cnt   <= '0;
          end
        end
        S_PRE: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) begin
            state <= S_SQS;
          end
        end
        S_SQS: state <= S_SQRT;
        S_SQRT: begin
          if (sq_done) begin
            cnt   <= '0;
            k     <= '0;
            state <= sing ? S_FIN : S_DIVS;
          end
        end
        S_DIVS: state <= S_DIV;
        S_DIV: begin
          if (dv_done) begin
            k     <= k + 2'd1;
            state <= (k == 2'd2) ? S_FIN : S_DIVS;
          end
        end
        S_FIN: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            running_min <= eov ? ngme_pkg::MAXV : cur_c;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      aa  <= s_tdata[31:0];
      bb  <= s_tdata[63:32];
      ab  <= s_tdata[95:64];
      ga  <= s_tdata[127:96];
      gb  <= s_tdata[159:128];
      eov <= s_tlast;
    end
    if (state == S_PRE) begin
      if (cnt == 3'd1) p_aabb <= prod[63:0];
      if (cnt == 3'd2) p_ab2  <= prod[63:0];
      if (cnt == 3'd3) p_d2   <= prod[64:0];
    end
    if (state == S_SQS) begin
      det  <= det_c;
      sing <= (det_c[31] || det_c == '0);
    end
    if (state == S_SQRT && sq_done) begin
      ev <= ngme_pkg::sat66(66'(ev_w));
    end
    if (state == S_DIV && dv_done) begin
      unique case (k)
        2'd0:    g11 <= qsat;
        2'd1:    g22 <= qsat;
        default: g12 <= qsat;
      endcase
    end
    if (state == S_FIN) begin
      unique case (cnt)
        3'd1:    pf0 <= prod[63:0];
        3'd2:    pf1 <= prod[63:0];
        3'd3:    pf2 <= prod[63:0];
        3'd4:    pf3 <= prod[63:0];
        default: ;
      endcase
    end
    if (load) begin
      out_a    <= na_c;
      out_b    <= nb_c;
      out_min  <= cur_c;
      out_sing <= sing;
      out_last <= eov;
    end
  end

  assign m_tdata = {out_min, out_b, out_a};
  assign m_tuser = out_sing;
  assign m_tlast = out_last;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in flight");

  a_min_cleared: assert property (@(posedge clk) disable iff (rst)
    (load && eov) |=> (running_min == ngme_pkg::MAXV))
    else $error("running minimum not cleared after last item");

  a_min_monotone: assert property (@(posedge clk) disable iff (rst)
    load |=> ($signed(out_min) <= $signed($past(running_min))))
    else $error("reported minimum above running minimum");

  a_sing_saturates: assert property (@(posedge clk) disable iff (rst)
    (load && sing) |=> ((out_a == ngme_pkg::MAXV || out_a == ngme_pkg::MINV) &&
                        (out_b == ngme_pkg::MAXV || out_b == ngme_pkg::MINV)))
    else $error("singular result not saturated");

  a_div_regular: assert property (@(posedge clk) disable iff (rst)
    dv_start |-> (!sing && !det[31] && det != '0))
    else $error("division started on a singular matrix");

endmodule

@@ bench/natural_gradient_2x2_min_eigen_unit_tb.sv @@
// ----------------------------------------------------------------------------
// natural_gradient_2x2_min_eigen_unit_tb
// Drives random and directed Fisher matrices and gradients through the unit
// and compares each result item against a fixed-point predictor of the
// natural gradient, the singular flag and the running minimum eigenvalue.
// ----------------------------------------------------------------------------
module natural_gradient_2x2_min_eigen_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] na;
    logic signed [31:0] nb;
    logic signed [31:0] ev;
    logic               sing;
    logic               last;
  } grad_result_t;

  class grad_scoreboard;
    grad_result_t pending[$];
    longint signed min_eig;
    int errors;

    function new();
      min_eig = 64'sd2147483647;
      errors = 0;
    endfunction

    static function longint signed clip(longint signed v);
      longint signed r;
      r = v;
      if (v > 64'sd2147483647) r = 64'sd2147483647;
      if (v < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    static function longint signed qdiv(longint signed a, longint signed b);
      longint unsigned ua, q;
      longint signed r;
      ua = (a < 0) ? longint'(-a) : a;
      q = (ua << 16) / longint'(unsigned'(b));
      if (q > (64'd1 << 62)) q = 64'd1 << 62;
      r = q;
      return clip(a < 0 ? -r : r);
    endfunction

    static function longint unsigned root(longint unsigned x);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= r + bitv) begin
          x -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return r;
    endfunction

    function void note_item(logic [159:0] d, logic last);
      longint signed aa, bb, ab, ga, gb, det, g11, g22, g12, na, nb, ev, cur, dd;
      longint unsigned ud, uab;
      grad_result_t e;
      aa = signed'(d[31:0]);
      bb = signed'(d[63:32]);
      ab = signed'(d[95:64]);
      ga = signed'(d[127:96]);
      gb = signed'(d[159:128]);
      det = clip((aa * bb - ab * ab) >>> 16);
      if (det > 0) begin
        g11 = qdiv(bb, det);
        g22 = qdiv(aa, det);
        g12 = qdiv(-ab, det);
        na = clip(((g11 * ga) >>> 16) + ((g12 * gb) >>> 16));
        nb = clip(((g12 * ga) >>> 16) + ((g22 * gb) >>> 16));
      end else begin
        na = (bb * ga >= ab * gb) ? 64'sd2147483647 : -64'sd2147483648;
        nb = (aa * gb >= ab * ga) ? 64'sd2147483647 : -64'sd2147483648;
      end
      dd = aa - bb;
      ud = (dd < 0) ? longint'(-dd) : dd;
      uab = (ab < 0) ? longint'(-ab) : ab;
      ev = clip(((aa + bb) >>> 1) - longint'(root(((ud * ud) >> 2) + uab * uab)));
      cur = (ev < min_eig) ? ev : min_eig;
      min_eig = last ? 64'sd2147483647 : cur;
      e.na = na[31:0];
      e.nb = nb[31:0];
      e.ev = cur[31:0];
      e.sing = (det <= 0);
      e.last = last;
      pending.push_back(e);
    endfunction

    function void check_result(logic [95:0] d, logic sing, logic last);
      grad_result_t e;
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.na) begin
        $error("nat_a expected %h got %h", e.na, d[31:0]); errors++;
      end
      if (d[63:32] !== e.nb) begin
        $error("nat_b expected %h got %h", e.nb, d[63:32]); errors++;
      end
      if (d[95:64] !== e.ev) begin
        $error("min_eigen expected %h got %h", e.ev, d[95:64]); errors++;
      end
      if (sing !== e.sing) begin
        $error("singular expected %b got %b", e.sing, sing); errors++;
      end
      if (last !== e.last) begin
        $error("end_out expected %b got %b", e.last, last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [159:0] s_tdata = '0;  // fisher_aa, fisher_bb, fisher_ab, grad_a, grad_b
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [95:0] m_tdata;        // nat_a, nat_b, min_eigen
  logic m_tuser;               // singular
  logic m_tlast;

  grad_scoreboard sb = new();
  int send_idle = 38;
  int recv_idle = 72;
  bit hold_recv = 0;
  longint cycles = 0;

  natural_gradient_2x2_min_eigen_unit dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd2500000) begin
      $display("TEST FAILED");
      $finish;
    end
    if (s_tvalid && s_tready) sb.note_item(s_tdata, s_tlast);
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  always @(negedge clk) begin
    if (rst || hold_recv) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(7))
      0: w = 32'h7fffffff;
      1: w = 32'h80000000;
      2: w = $urandom_range(0, 32'h00040000);
      3: w = -$urandom_range(0, 32'h00040000);
      4: w = 32'h00010000;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_item(logic [31:0] aa, bb, ab, ga, gb, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= {gb, ga, ab, bb, aa};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  task automatic send_random(int n);
    logic [31:0] aa, bb, ab;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) begin
        // Mostly well-conditioned positive definite matrices.
        aa = $urandom_range(32'h00001000, 32'h00400000);
        bb = $urandom_range(32'h00001000, 32'h00400000);
        ab = $urandom_range(0, 32'h00000fff) - 32'h800;
        send_item(aa, bb, ab, rand_word(), rand_word(), $urandom_range(7) == 0);
      end else begin
        send_item(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                  $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_item(32'h00010000, 32'h00010000, 32'h0, 32'h00010000, 32'hffff0000, 0);
    send_item(32'h00020000, 32'h00030000, 32'h00008000, 32'h7fffffff, 32'h80000000, 0);
    send_item(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 32'h0, 0);
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1);
    send_item(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1, 0);
    send_item(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send_item(32'h80000000, 32'h7fffffff, 32'h0, 32'h12345678, 32'hedcba987, 1);
    send_item(32'h00000001, 32'h00000001, 32'h0, 32'h7fffffff, 32'h7fffffff, 0);
    send_item(32'hffff0000, 32'hfffe0000, 32'h0, 32'h00010000, 32'h00010000, 1);
    send_item(32'h00000100, 32'h00000100, 32'hffffff00, 32'h80000000, 32'h80000000, 1);
    send_item(32'h7fffffff, 32'h00000001, 32'h0, 32'h55555555, 32'haaaaaaaa, 0);
    send_item(32'h00010000, 32'h00010000, 32'h00000001, 32'hffffffff, 32'hffffffff, 1);
    send_random(550);
    drain();
    send_idle = 72;
    recv_idle = 38;
    hold_recv = 1;
    fork
      begin
        int k;
        for (k = 0; k < 3000; k++) @(negedge clk);
        hold_recv = 0;
      end
      send_random(10);
    join
    send_random(570);
    send_idle = 0;
    recv_idle = 0;
    send_random(610);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
